// ----- rtl/core/psfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package psfb_pkg;

  localparam int unsigned TableEntriesDefault = 64;

  localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;

  localparam logic [63:0] WINDOW_RESET       = 64'd1000000000;
  localparam logic [31:0] PACKET_LIMIT_RESET = 32'd1000;
  localparam logic [31:0] SYN_LIMIT_RESET    = 32'd100;
  localparam logic [63:0] BLOCK_RESET        = 64'd10000000000;

  localparam logic [7:0] REG_WINDOW       = 8'd0;
  localparam logic [7:0] REG_PACKET_LIMIT = 8'd1;
  localparam logic [7:0] REG_SYN_LIMIT    = 8'd2;
  localparam logic [7:0] REG_BLOCK        = 8'd3;

  localparam logic [2:0] CLASS_NONE  = 3'd0;
  localparam logic [2:0] CLASS_TCP   = 3'd1;
  localparam logic [2:0] CLASS_UDP   = 3'd2;
  localparam logic [2:0] CLASS_ICMP  = 3'd3;
  localparam logic [2:0] CLASS_OTHER = 3'd4;

  typedef struct packed {
    logic        headers_complete;
    logic [15:0] ethertype;
    logic [3:0]  header_words;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic        tcp_complete;
    logic        syn_bit;
    logic        ack_bit;
    logic [63:0] arrival_ns;
  } in_item_t;

  typedef struct packed {
    logic       verdict;
    logic [2:0] traffic_class;
    logic       open_attempt;
    logic       block_event;
    logic       new_source;
  } out_item_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic        match;
    logic        update;
    logic [31:0] key;
    logic [63:0] now;
    logic        open;
    logic [63:0] win;
    logic [31:0] plim;
    logic [31:0] slim;
    logic [63:0] blk;
  } cell_cmd_t;

  typedef struct packed {
    logic drop;
    logic block_event;
  } cell_flags_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/psfb_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psfb_cell #(
  parameter int unsigned N   = psfb_pkg::TableEntriesDefault,
  parameter int unsigned IDX = 0,
  parameter int unsigned RW  = $clog2(N),
  parameter int unsigned CW  = $clog2(N + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire psfb_pkg::cell_cmd_t   cmd,
  input  wire logic                  any_hit,
  input  wire logic [RW-1:0]         old_rank,
  input  wire logic [CW-1:0]         fill,
  output logic                       hit,
  output logic [RW-1:0]              rank,
  output psfb_pkg::cell_flags_t      flags
);

  logic        valid;
  logic [31:0] source;
  logic [63:0] win_start;
  logic [31:0] packet_count;
  logic [31:0] syn_cnt;
  logic        blocked;
  logic [63:0] block_end;

  logic        full, victim, target, hold, fresh, trip, trip_run, trip_new;
  logic [31:0] pc_run, sc_run, sc_new, pc2, sc2;
  logic [63:0] ws1, end_new;
  logic [64:0] end_sum;

  always_comb begin
    full    = (fill == CW'(N));
    victim  = full ? (valid && rank == RW'(N - 1)) : (fill == CW'(IDX));
    target  = cmd.update && (any_hit ? hit : victim);
    hold    = blocked && (cmd.now < block_end);
    // expired block or rolled window both restart counting from now
    fresh    = blocked || ((cmd.now - win_start) > cmd.win);
    pc_run   = psfb_pkg::sat_inc32(packet_count);
    sc_run   = cmd.open ? psfb_pkg::sat_inc32(syn_cnt) : syn_cnt;
    sc_new   = {31'd0, cmd.open};
    trip_run = (pc_run > cmd.plim) || (sc_run > cmd.slim);
    trip_new = (32'd1 > cmd.plim) || (sc_new > cmd.slim);
    pc2      = fresh ? 32'd1 : pc_run;
    sc2      = fresh ? sc_new : sc_run;
    ws1      = fresh ? cmd.now : win_start;
    trip     = fresh ? trip_new : trip_run;
    end_sum = {1'b0, cmd.now} + {1'b0, cmd.blk};
    end_new = end_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : end_sum[63:0];
    flags.drop        = target && any_hit && (hold || trip);
    flags.block_event = target && any_hit && !hold && trip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (cmd.match) begin
        hit <= valid && (source == cmd.key);
      end
      if (target && !any_hit) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (target) begin
      rank <= '0;
      if (!any_hit) begin
        source       <= cmd.key;
        win_start    <= cmd.now;
        packet_count <= 32'd1;
        syn_cnt      <= {31'd0, cmd.open};
        blocked      <= 1'b0;
        block_end    <= '0;
      end else if (!hold) begin
        packet_count <= pc2;
        syn_cnt      <= sc2;
        win_start    <= ws1;
        blocked      <= trip;
        if (trip) begin
          block_end <= end_new;
        end
      end
    end else if (cmd.update && valid && rank < old_rank) begin
      rank <= rank + RW'(1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/per_source_flood_blocker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  | signals                              | accepted when
// item in  | start, busy, item                    | start && !busy
// result   | done, result                         | done (one cycle, no stall)
// config   | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// each item passes through accept, tag compare in all cells, hit reduction
// and cell update; the result strobes in the cycle after the update
// a new item is taken once the previous one has left the update step
// reset clears the valid bits of all cells and the fill count at once
// the receiver cannot stall; config writes are always ready
module per_source_flood_blocker #(
  parameter int unsigned TABLE_ENTRIES = psfb_pkg::TableEntriesDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire psfb_pkg::in_item_t    item,
  output logic                       done,
  output psfb_pkg::out_item_t        result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_index,
  input  wire logic [63:0]           cfg_data
);

  localparam int unsigned RW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_SELECT, S_UPDATE} state_t;
  state_t state;

  // configuration
  logic [63:0] window_length_ns, block_length_ns;
  logic [31:0] packet_limit, syn_limit;

  // item held for the whole pass
  psfb_pkg::in_item_t pkt;
  logic       tracked;
  logic [2:0] cls;
  logic       open;

  logic [CW-1:0] fill;
  logic          any_hit;
  logic [RW-1:0] hit_rank;
  logic [RW-1:0] old_rank;

  psfb_pkg::cell_cmd_t   cmd;
  logic [TABLE_ENTRIES-1:0] hits;
  logic [RW-1:0]         ranks [TABLE_ENTRIES];
  psfb_pkg::cell_flags_t flags [TABLE_ENTRIES];

  logic          hit_any_c;
  logic [RW-1:0] hit_rank_c;
  logic          drop_c, event_c;
  logic          full;

  // decode of the incoming item
  logic       in_ip, in_tracked, in_open;
  logic [2:0] in_cls;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign full      = (fill == CW'(TABLE_ENTRIES));

  always_comb begin
    in_ip = item.headers_complete && (item.ethertype == psfb_pkg::ETHERTYPE_IPV4)
            && (item.header_words >= psfb_pkg::MIN_HEADER_WORDS);
    if (!in_ip) begin
      in_cls = psfb_pkg::CLASS_NONE;
    end else if (item.protocol_number == psfb_pkg::PROTO_TCP) begin
      in_cls = psfb_pkg::CLASS_TCP;
    end else if (item.protocol_number == psfb_pkg::PROTO_UDP) begin
      in_cls = psfb_pkg::CLASS_UDP;
    end else if (item.protocol_number == psfb_pkg::PROTO_ICMP) begin
      in_cls = psfb_pkg::CLASS_ICMP;
    end else begin
      in_cls = psfb_pkg::CLASS_OTHER;
    end
    // truncated tcp passes untracked
    in_tracked = in_ip && !((in_cls == psfb_pkg::CLASS_TCP) && !item.tcp_complete);
    in_open    = in_tracked && (in_cls == psfb_pkg::CLASS_TCP)
                 && item.syn_bit && !item.ack_bit;
  end

  // broadcast to the cells; a zero window selects all reset settings
  always_comb begin
    cmd.match  = (state == S_MATCH);
    cmd.update = (state == S_UPDATE) && tracked;
    cmd.key    = pkt.source_address;
    cmd.now    = pkt.arrival_ns;
    cmd.open   = open;
    if (window_length_ns != 64'd0) begin
      cmd.win  = window_length_ns;
      cmd.plim = packet_limit;
      cmd.slim = syn_limit;
      cmd.blk  = block_length_ns;
    end else begin
      cmd.win  = psfb_pkg::WINDOW_RESET;
      cmd.plim = psfb_pkg::PACKET_LIMIT_RESET;
      cmd.slim = psfb_pkg::SYN_LIMIT_RESET;
      cmd.blk  = psfb_pkg::BLOCK_RESET;
    end
  end

  // ranks below this age by one: the hit slot's rank, the oldest rank when
  // evicting, or the fill count when a free slot is taken (all valid age)
  always_comb begin
    if (any_hit) begin
      old_rank = hit_rank;
    end else if (full) begin
      old_rank = RW'(TABLE_ENTRIES - 1);
    end else begin
      old_rank = fill[RW-1:0];
    end
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      psfb_cell #(
        .N   (TABLE_ENTRIES),
        .IDX (g),
        .RW  (RW),
        .CW  (CW)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .any_hit  (any_hit),
        .old_rank (old_rank),
        .fill     (fill),
        .hit      (hits[g]),
        .rank     (ranks[g]),
        .flags    (flags[g])
      );
    end
  endgenerate

  // or-reduction over the cells; at most one cell hits or is targeted
  always_comb begin
    hit_any_c  = |hits;
    hit_rank_c = '0;
    drop_c     = 1'b0;
    event_c    = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_rank_c = hit_rank_c | (ranks[i] & {RW{hits[i]}});
      drop_c     = drop_c | flags[i].drop;
      event_c    = event_c | flags[i].block_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_ns <= psfb_pkg::WINDOW_RESET;
      packet_limit     <= psfb_pkg::PACKET_LIMIT_RESET;
      syn_limit        <= psfb_pkg::SYN_LIMIT_RESET;
      block_length_ns  <= psfb_pkg::BLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psfb_pkg::REG_WINDOW:       window_length_ns <= cfg_data;
        psfb_pkg::REG_PACKET_LIMIT: packet_limit     <= cfg_data[31:0];
        psfb_pkg::REG_SYN_LIMIT:    syn_limit        <= cfg_data[31:0];
        psfb_pkg::REG_BLOCK:        block_length_ns  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      fill  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_SELECT;
        end
        S_SELECT: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (tracked && !any_hit && !full) begin
            fill <= fill + CW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      pkt     <= item;
      tracked <= in_tracked;
      cls     <= in_cls;
      open    <= in_open;
    end
    if (state == S_SELECT) begin
      any_hit  <= hit_any_c;
      hit_rank <= hit_rank_c;
    end
    if (state == S_UPDATE) begin
      result.verdict       <= tracked && drop_c;
      result.traffic_class <= cls;
      result.open_attempt  <= open;
      result.block_event   <= tracked && event_c;
      result.new_source    <= tracked && !any_hit;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("result strobe without an update step");
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hits))
    else $error("source held in more than one cell");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_UPDATE) |=> $stable(fill))
    else $error("fill count moved outside the update step");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import psfb_pkg::*;

  localparam int          SLOTS      = 64;
  localparam int          CYCLE_CAP  = 400000;
  localparam logic [7:0]  REG_UNUSED = 8'd9;   // no such register, write is dropped

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    item;
  logic        done;
  out_item_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;

  per_source_flood_blocker u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------
  // predicted table and settings
  // ---------------------------------------------------------------
  logic [63:0] win_setting;
  logic [31:0] pkt_setting;
  logic [31:0] syn_setting;
  logic [63:0] blk_setting;

  logic        tbl_valid   [SLOTS];
  logic [31:0] tbl_src     [SLOTS];
  logic [63:0] tbl_wstart  [SLOTS];
  logic [31:0] tbl_pkts    [SLOTS];
  logic [31:0] tbl_syns    [SLOTS];
  logic        tbl_blocked [SLOTS];
  logic [63:0] tbl_bend    [SLOTS];
  int unsigned tbl_age     [SLOTS];

  in_item_t  pending_items[$];   // items waiting for the driver
  out_item_t verdicts_due[$];    // predicted results, oldest first
  int        errors;
  int        cycles;
  bit        steady;             // no idling on the sender side
  logic [63:0] arrival_clock;
  logic [31:0] src_pool[128];

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // make slot s youngest; slots younger than it age by one
  function automatic void make_youngest(input int s, input int unsigned rank);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && i != s && tbl_age[i] < rank) tbl_age[i]++;
    tbl_age[s] = 0;
  endfunction

  function automatic out_item_t judge_packet(input in_item_t it);
    out_item_t   r;
    logic [63:0] win, blk;
    logic [31:0] plim, slim;
    logic        open;
    int          s;
    int unsigned oldest;
    r = '0;
    open = 1'b0;
    s = -1;
    // untracked: short, truncated or not ipv4
    if (!it.headers_complete || it.ethertype != ETHERTYPE_IPV4 ||
        it.header_words < MIN_HEADER_WORDS)
      return r;
    // zero window means all four settings fall back to reset values
    if (win_setting != 0) begin
      win = win_setting; plim = pkt_setting; slim = syn_setting; blk = blk_setting;
    end else begin
      win = WINDOW_RESET; plim = PACKET_LIMIT_RESET; slim = SYN_LIMIT_RESET; blk = BLOCK_RESET;
    end
    if (it.protocol_number == PROTO_TCP) r.traffic_class = CLASS_TCP;
    else if (it.protocol_number == PROTO_UDP) r.traffic_class = CLASS_UDP;
    else if (it.protocol_number == PROTO_ICMP) r.traffic_class = CLASS_ICMP;
    else r.traffic_class = CLASS_OTHER;
    if (r.traffic_class == CLASS_TCP) begin
      if (!it.tcp_complete) return r;   // truncated tcp passes untracked
      open = it.syn_bit && !it.ack_bit;
    end
    r.open_attempt = open;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && tbl_valid[i] && tbl_src[i] == it.source_address) s = i;
    if (s < 0) begin
      // new source: free slot first, else least recently used
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && !tbl_valid[i]) s = i;
      if (s < 0) begin
        oldest = 0;
        s = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_age[i] >= oldest) begin oldest = tbl_age[i]; s = i; end
        make_youngest(s, oldest);
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i]) tbl_age[i]++;
        tbl_age[s] = 0;
      end
      tbl_valid[s] = 1'b1;
      tbl_src[s] = it.source_address;
      tbl_wstart[s] = it.arrival_ns;
      tbl_pkts[s] = 32'd1;
      tbl_syns[s] = {31'd0, open};
      tbl_blocked[s] = 1'b0;
      tbl_bend[s] = '0;
      r.new_source = 1'b1;
      return r;
    end
    make_youngest(s, tbl_age[s]);
    if (tbl_blocked[s]) begin
      if (it.arrival_ns < tbl_bend[s]) begin
        r.verdict = 1'b1;
        return r;
      end
      // block expired: restart counting from now
      tbl_blocked[s] = 1'b0;
      tbl_pkts[s] = '0;
      tbl_syns[s] = '0;
      tbl_wstart[s] = it.arrival_ns;
    end
    if (it.arrival_ns - tbl_wstart[s] > win) begin
      tbl_wstart[s] = it.arrival_ns;
      tbl_pkts[s] = '0;
      tbl_syns[s] = '0;
    end
    tbl_pkts[s] = bump32(tbl_pkts[s]);
    if (open) tbl_syns[s] = bump32(tbl_syns[s]);
    if (tbl_pkts[s] > plim || tbl_syns[s] > slim) begin
      tbl_blocked[s] = 1'b1;
      tbl_bend[s] = (it.arrival_ns > 64'hFFFF_FFFF_FFFF_FFFF - blk) ?
                    64'hFFFF_FFFF_FFFF_FFFF : it.arrival_ns + blk;
      r.verdict = 1'b1;
      r.block_event = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // clock, reset, cycle cap
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // driver: takes items from pending_items, one per handshake
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    logic     go;
    in_item_t nxt;
    go = 1'b0;
    nxt = item;
    if (!rst) begin
      if (start && !busy) begin
        // item accepted at this edge, predict now
        verdicts_due.push_back(judge_packet(pending_items.pop_front()));
        if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 17)) begin
          go = 1'b1;
          nxt = pending_items[0];
        end
      end else if (start) begin
        go = 1'b1;   // still waiting on busy, hold the item
      end else if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 17)) begin
        go = 1'b1;
        nxt = pending_items[0];
      end
    end
    start <= go;
    item <= nxt;
  end

  // ---------------------------------------------------------------
  // monitor: every strobe is checked against the oldest prediction
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (result.verdict !== want.verdict) begin
          $display("%0t: verdict expected %b actual %b", $time, want.verdict, result.verdict);
          errors++;
        end
        if (result.traffic_class !== want.traffic_class) begin
          $display("%0t: traffic_class expected %0d actual %0d", $time,
                   want.traffic_class, result.traffic_class);
          errors++;
        end
        if (result.open_attempt !== want.open_attempt) begin
          $display("%0t: open_attempt expected %b actual %b", $time,
                   want.open_attempt, result.open_attempt);
          errors++;
        end
        if (result.block_event !== want.block_event) begin
          $display("%0t: block_event expected %b actual %b", $time,
                   want.block_event, result.block_event);
          errors++;
        end
        if (result.new_source !== want.new_source) begin
          $display("%0t: new_source expected %b actual %b", $time,
                   want.new_source, result.new_source);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  function automatic in_item_t mk(input logic hc, input logic [15:0] et, input logic [3:0] w,
                                  input logic [7:0] p, input logic [31:0] src, input logic tc,
                                  input logic syn, input logic ack, input logic [63:0] t);
    in_item_t it;
    it.headers_complete = hc; it.ethertype = et; it.header_words = w;
    it.protocol_number = p; it.source_address = src; it.tcp_complete = tc;
    it.syn_bit = syn; it.ack_bit = ack; it.arrival_ns = t;
    return it;
  endfunction

  // mostly well-formed packets from a small source pool; some noise
  function automatic in_item_t rand_packet(input int pool, input int step);
    in_item_t it;
    int       pick;
    it = '0;
    arrival_clock = arrival_clock + $urandom_range(0, step);
    if ($urandom_range(0, 99) < 8) begin
      it = {$urandom, $urandom, $urandom, $urandom};
      it.arrival_ns = {$urandom, $urandom};
      return it;
    end
    it.headers_complete = ($urandom_range(0, 99) < 97);
    it.ethertype = ($urandom_range(0, 99) < 97) ? ETHERTYPE_IPV4 : 16'($urandom);
    it.header_words = ($urandom_range(0, 99) < 95) ? 4'($urandom_range(5, 15))
                                                   : 4'($urandom_range(0, 4));
    pick = $urandom_range(0, 9);
    if (pick < 5) it.protocol_number = PROTO_TCP;
    else if (pick < 7) it.protocol_number = PROTO_UDP;
    else if (pick < 9) it.protocol_number = PROTO_ICMP;
    else it.protocol_number = 8'($urandom);
    it.tcp_complete = ($urandom_range(0, 99) < 93);
    it.syn_bit = $urandom_range(0, 1);
    it.ack_bit = $urandom_range(0, 2) == 0;
    it.source_address = src_pool[$urandom_range(0, pool - 1)];
    it.arrival_ns = arrival_clock;
    // time going backwards now and then
    if ($urandom_range(0, 99) < 4) it.arrival_ns = arrival_clock - $urandom_range(1, 2 * step + 1);
    return it;
  endfunction

  task automatic set_reg(input logic [7:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW:       win_setting = val;
      REG_PACKET_LIMIT: pkt_setting = val[31:0];
      REG_SYN_LIMIT:    syn_setting = val[31:0];
      REG_BLOCK:        blk_setting = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [63:0] w, input logic [31:0] p, input logic [31:0] s,
                         input logic [63:0] b);
    set_reg(REG_WINDOW, w);
    set_reg(REG_PACKET_LIMIT, {32'd0, p});
    set_reg(REG_SYN_LIMIT, {32'd0, s});
    set_reg(REG_BLOCK, b);
  endtask

  // wait until every item is out and every result back
  task automatic drain;
    do @(posedge clk);
    while (pending_items.size() > 0 || start || verdicts_due.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int pool, input int step);
    for (int k = 0; k < SLOTS * 2; k++) src_pool[k] = $urandom;
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    for (int k = 0; k < n; k++) pending_items.push_back(rand_packet(pool, step));
    drain();
  endtask

  // ---------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------
  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    arrival_clock = 64'd1000;
    win_setting = WINDOW_RESET;
    pkt_setting = PACKET_LIMIT_RESET;
    syn_setting = SYN_LIMIT_RESET;
    blk_setting = BLOCK_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0; tbl_src[i] = '0; tbl_wstart[i] = '0; tbl_pkts[i] = '0;
      tbl_syns[i] = '0; tbl_blocked[i] = 1'b0; tbl_bend[i] = '0; tbl_age[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: untracked cases and each class
    pending_items.push_back(mk(0, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'h1, 1, 0, 0, 64'd0));
    pending_items.push_back(mk(1, 16'h86DD, 5, PROTO_UDP, 32'h1, 1, 0, 0, 64'd1));
    pending_items.push_back(mk(1, 16'hFFFF, 15, PROTO_UDP, 32'h1, 1, 0, 0, 64'd1));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 4, PROTO_UDP, 32'h1, 1, 0, 0, 64'd2));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 0, PROTO_UDP, 32'h1, 1, 0, 0, 64'd2));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h2, 0, 1, 0, 64'd3));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_TCP, 32'h0, 1, 1, 0, 64'd4));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 15, PROTO_TCP, 32'h0, 1, 1, 1, 64'd5));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 6, PROTO_UDP, 32'hFFFF_FFFF, 1, 1, 0,
                               64'd6));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_ICMP, 32'hFFFF_FFFF, 0, 0, 0,
                               64'd7));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, 8'hFF, 32'h1234_5678, 0, 1, 1, 64'd8));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, 8'h00, 32'h1234_5678, 1, 0, 1,
                               64'hFFFF_FFFF_FFFF_FFFF));
    drain();

    // directed, tight limits: block, drop while blocked, expiry, window roll, time backwards
    set_all(64'd100, 32'd2, 32'd1, 64'd50);
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_TCP, 32'hA, 1, 1, 0, 64'd1000));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_TCP, 32'hA, 1, 1, 0, 64'd1001));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hA, 1, 0, 0, 64'd1020));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hA, 1, 0, 0, 64'd1051));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hB, 1, 0, 0, 64'd2000));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hB, 1, 0, 0, 64'd2001));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hB, 1, 0, 0, 64'd2200));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hB, 1, 0, 0, 64'd1500));
    pending_items.push_back(mk(1, ETHERTYPE_IPV4, 5, PROTO_UDP, 32'hB, 1, 0, 0, 64'd2201));
    drain();
    set_reg(REG_UNUSED, 64'hDEAD_BEEF_0000_0001);

    // random phases over several settings
    set_all(WINDOW_RESET, PACKET_LIMIT_RESET, SYN_LIMIT_RESET, BLOCK_RESET);
    random_phase(150, 8, 1000);
    set_all(64'd1000, 32'd6, 32'd2, 64'd2000);
    steady = 1'b1;
    random_phase(300, 6, 120);
    steady = 1'b0;
    set_all(64'd1000, 32'd0, 32'd0, 64'd500);
    random_phase(150, 10, 100);
    set_all(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(100, 8, 100);
    set_all(64'd0, 32'd3, 32'd1, 64'd10);   // zero window: reset values apply
    random_phase(100, 8, 1000);
    set_all(64'd500, 32'd4, 32'd1, 64'd1000);
    random_phase(300, 100, 60);              // more sources than slots
    set_all(64'd1, 32'd2, 32'd1, 64'd0);
    random_phase(300, 4, 3);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
